[design/i2c_master_bit_engine_assert.svh]
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Clocked property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// property must hold at every edge outside reset
`define I2CM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define I2CM_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[design/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, phase constants and the engine state record.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_ACK   = 3'd5;

	localparam logic [4:0] WR_LAST_BIT = 5'd16;
	localparam logic [4:0] WR_ACK_HIGH = 5'd17;
	localparam logic [4:0] RD_LAST     = 5'd23;
	localparam logic [4:0] RD_END      = 5'd24;

	typedef struct packed {
		logic [4:0] phase;
		logic [1:0] tri_cnt;
		logic [2:0] active_cmd;
		logic [7:0] shift_reg;
		logic       ack_bit;
		logic       scl_out;
		logic       sda_out;
		logic [7:0] rx_data;
	} state_t;

endpackage

[design/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine
// Top level: engine state, tick logic and registered result.
// ----------------------------------------------------------------------------
// Each input beat is one tick from the bus prescaler, carrying the command
// request and the sampled SDA level. The engine takes one beat every clock
// cycle while in_stall is low; the result for a beat (SCL/SDA drive, busy,
// done, last read byte, last slave ack) appears in the output register on the
// next cycle. The single output register decides the rate: a new beat is
// taken whenever that register is empty or is being emptied in the same
// cycle. A command given while busy is ignored.
module i2c_master_bit_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cmd,
	input  logic [7:0] tx_byte,
	input  logic       ack_level,
	input  logic       sda_sample,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rx_byte,
	output logic       slave_ack
);
	import i2cm_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   step_done;
	logic   accept;
	logic   out_valid_q;
	logic   scl_q, sda_q, busy_q, done_q, ack_q;
	logic [7:0] rx_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	i2cm_step u_step (
		.cur        (state_q),
		.cmd        (cmd),
		.tx_byte    (tx_byte),
		.ack_level  (ack_level),
		.sda_sample (sda_sample),
		.nxt        (state_nxt),
		.done       (step_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: 5'd0, tri_cnt: 2'd0, active_cmd: CMD_NONE,
			             shift_reg: 8'd0, ack_bit: 1'b1, scl_out: 1'b1,
			             sda_out: 1'b1, rx_data: 8'd0};
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			scl_q  <= state_nxt.scl_out;
			sda_q  <= state_nxt.sda_out;
			busy_q <= (state_nxt.active_cmd != CMD_NONE);
			done_q <= step_done;
			rx_q   <= state_nxt.rx_data;
			ack_q  <= state_nxt.ack_bit;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = scl_q;
	assign sda_level = sda_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign rx_byte   = rx_q;
	assign slave_ack = ack_q;

endmodule

[design/i2cm_step.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine step
// Next-state logic for one tick of the active command.
// ----------------------------------------------------------------------------
module i2cm_step (
	input  i2cm_pkg::state_t cur,
	input  logic [2:0]       cmd,
	input  logic [7:0]       tx_byte,
	input  logic             ack_level,
	input  logic             sda_sample,
	output i2cm_pkg::state_t nxt,
	output logic             done
);
	import i2cm_pkg::*;

	logic [4:0] s;
	logic [1:0] r;
	logic       run;
	logic       fin;
	state_t     st;

	always_comb begin
		st  = cur;
		s   = cur.phase;
		r   = cur.tri_cnt;
		run = 1'b0;
		fin = 1'b0;
		if (cur.active_cmd == CMD_NONE) begin
			if (cmd == CMD_START || cmd == CMD_STOP || cmd == CMD_WRITE ||
			    cmd == CMD_READ || cmd == CMD_ACK) begin
				st.active_cmd = cmd;
				s   = 5'd0;
				r   = 2'd0;
				run = 1'b1;
				if (cmd == CMD_WRITE) st.shift_reg = tx_byte;
				if (cmd == CMD_READ) st.shift_reg = 8'd0;
				if (cmd == CMD_ACK) begin
					st.scl_out = 1'b0;
					st.sda_out = ack_level;
				end
			end
		end else begin
			run = 1'b1;
		end

		if (run) begin
			unique case (st.active_cmd)
				CMD_START: begin
					priority if (s == 5'd0) st.sda_out = 1'b1;
					else if (s == 5'd1) st.scl_out = 1'b1;
					else if (s == 5'd2) st.sda_out = 1'b0;
					else begin
						st.scl_out = 1'b0;
						fin = 1'b1;
					end
				end
				CMD_STOP: begin
					priority if (s == 5'd0) begin
						st.scl_out = 1'b0;
						st.sda_out = 1'b0;
					end else if (s == 5'd1) st.scl_out = 1'b1;
					else begin
						st.sda_out = 1'b1;
						fin = 1'b1;
					end
				end
				CMD_ACK: begin
					if (s == 5'd1) st.scl_out = 1'b1;
					else if (s != 5'd0) begin
						st.scl_out = 1'b0;
						fin = 1'b1;
					end
				end
				CMD_WRITE: begin
					priority if (s < WR_LAST_BIT) begin
						if (!s[0]) begin
							st.scl_out = 1'b0;
							st.sda_out = st.shift_reg[7];
						end else begin
							st.scl_out   = 1'b1;
							st.shift_reg = {st.shift_reg[6:0], 1'b0};
						end
					end else if (s == WR_LAST_BIT) begin
						st.scl_out = 1'b0;
						st.sda_out = 1'b1;
					end else if (s == WR_ACK_HIGH) begin
						st.scl_out = 1'b1;
						st.ack_bit = sda_sample;
					end else begin
						st.scl_out = 1'b0;
						fin = 1'b1;
					end
				end
				CMD_READ: begin
					st.sda_out = 1'b1;
					priority if (s >= RD_END) begin
						st.scl_out = 1'b0;
						st.rx_data = st.shift_reg;
						fin = 1'b1;
					end else if (r == 2'd1) begin
						st.scl_out   = 1'b1;
						st.shift_reg = {st.shift_reg[6:0], sda_sample};
					end else begin
						st.scl_out = 1'b0;
						if (s == RD_LAST) begin
							st.rx_data = st.shift_reg;
							fin = 1'b1;
						end
					end
				end
				default: fin = 1'b1;
			endcase

			if (fin) begin
				st.active_cmd = CMD_NONE;
				st.phase      = 5'd0;
				st.tri_cnt    = 2'd0;
			end else begin
				st.phase   = s + 5'd1;
				st.tri_cnt = (r == 2'd2) ? 2'd0 : r + 2'd1;
			end
		end
		nxt  = st;
		done = fin;
	end

endmodule

[design/i2cm_checker.sv]
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level checks on the engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_assert.svh"

module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_level,
	input logic       sda_level,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] rx_byte
);

	`I2CM_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(rx_byte) && $stable(scl_level) && $stable(sda_level)), "stalled result beat changed")
	`I2CM_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without a held result")
	`I2CM_ASSERT(a_beat_result, (in_valid && !in_stall) |=> out_valid, "accepted beat gave no result")
	`I2CM_NEVER(a_done_busy, out_valid && done_res && busy_res, "done and busy on one beat")

endmodule

bind i2c_master_bit_engine i2cm_checker u_chk (.*);
